/* design/fiws_pkg.sv */
// Shared constants and controller/datapath interface types for the frame interval stats unit.
package fiws_pkg;

  localparam int WINDOW = 256;
  localparam int ADDR_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int TS_W   = 64;
  localparam int IV_W   = 32;
  localparam int SUM_W  = 40;
  localparam int AVG_W  = 32;
  localparam int RATE_W = 24;
  localparam int NUM_W  = RATE_W + CNT_W;
  localparam int DIV_W  = 40;

  localparam logic [RATE_W-1:0] RATE_SCALE = RATE_W'(10000000);
  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(10000000);
  localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(WINDOW);
  localparam logic [ADDR_W-1:0] POS_LAST   = ADDR_W'(WINDOW - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic commit;
    logic start;
    logic latch_avg;
    logic latch_rate;
    logic publish;
  } fiws_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic div_done;
    logic scan_done;
    logic out_free;
  } fiws_status_t;

endpackage

/* design/frame_interval_window_stats_unit.sv */
// Top level of the sliding-window frame interval statistics unit.
// Each input beat runs through commit, the two divisions (average, then rate) and the peak walk
// through the single read port of the interval memory; the walk runs alongside the divisions,
// and the result is published once both are done. One input beat is taken at a time; the next
// is taken once the result is loaded, and a stalled output holds it off.
// Reset is synchronous and clears counters, sums and handshake state; the interval memory
// is not cleared, since an entry is only read after it has been written.
module frame_interval_window_stats_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [fiws_pkg::TS_W-1:0]   timestamp_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        interval_recorded,
  output logic [fiws_pkg::CNT_W-1:0]  frame_count,
  output logic [fiws_pkg::SUM_W-1:0]  window_sum_us,
  output logic [fiws_pkg::AVG_W-1:0]  average_us,
  output logic [fiws_pkg::IV_W-1:0]   peak_us,
  output logic [fiws_pkg::RATE_W-1:0] rate_tenths_fps
);
  import fiws_pkg::*;

  fiws_cmd_t    cmd;
  fiws_status_t status;

  fiws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  fiws_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .status            (status),
    .timestamp_us      (timestamp_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .interval_recorded (interval_recorded),
    .frame_count       (frame_count),
    .window_sum_us     (window_sum_us),
    .average_us        (average_us),
    .peak_us           (peak_us),
    .rate_tenths_fps   (rate_tenths_fps)
  );

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("controller issued overlapping commands");

  // After an input beat the unit is busy until its result is loaded.
  assert property (@(posedge clk) disable iff (rst) (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again before the result was produced");

  // A delivered result never reports more intervals than the window holds.
  assert property (@(posedge clk) disable iff (rst) out_valid |-> (frame_count <= CNT_FULL))
    else $error("fill count exceeds the window depth");

  // A result that recorded an interval always has a nonempty window.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && interval_recorded) |-> (frame_count != '0))
    else $error("recorded interval with an empty window");

endmodule

/* design/fiws_divider.sv */
// Restoring unsigned divider that produces one quotient bit per cycle.
module fiws_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [fiws_pkg::DIV_W-1:0] dividend,
  input  logic [fiws_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [fiws_pkg::DIV_W-1:0] quotient
);
  import fiws_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic              busy;
  logic [STEP_W-1:0] steps;
  logic [DIV_W:0]    rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dvsr;
  logic [DIV_W:0]    rem_shift;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the subtract.
  assign rem_shift = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign fits      = rem_shift >= {1'b0, dvsr};
  assign quotient  = quo;

  // Control: step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Data: remainder and quotient shift registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= fits ? (rem_shift - {1'b0, dvsr}) : rem_shift;
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

endmodule

/* design/fiws_ctrl.sv */
// Controller state machine that sequences update, scan, divisions and result hand-off.
module fiws_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  fiws_pkg::fiws_status_t status,
  output fiws_pkg::fiws_cmd_t    cmd
);
  import fiws_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_COMMIT   = 7'b0000010,
    S_START    = 7'b0000100,
    S_DIV_AVG  = 7'b0001000,
    S_DIV_RATE = 7'b0010000,
    S_SCAN     = 7'b0100000,
    S_PUBLISH  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = S_DIV_AVG;
      end
      S_DIV_AVG: begin
        if (status.div_done) begin
          cmd.latch_avg = 1'b1;
          state_next    = S_DIV_RATE;
        end
      end
      S_DIV_RATE: begin
        if (status.div_done) begin
          cmd.latch_rate = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.scan_done) begin
          state_next = S_PUBLISH;
        end
      end
      S_PUBLISH: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/fiws_datapath.sv */
// Datapath: interval ring memory, window counters, peak scan, divider operands and output beat.
module fiws_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  fiws_pkg::fiws_cmd_t         cmd,
  output fiws_pkg::fiws_status_t      status,
  input  logic [fiws_pkg::TS_W-1:0]   timestamp_us,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        interval_recorded,
  output logic [fiws_pkg::CNT_W-1:0]  frame_count,
  output logic [fiws_pkg::SUM_W-1:0]  window_sum_us,
  output logic [fiws_pkg::AVG_W-1:0]  average_us,
  output logic [fiws_pkg::IV_W-1:0]   peak_us,
  output logic [fiws_pkg::RATE_W-1:0] rate_tenths_fps
);
  import fiws_pkg::*;

  logic [IV_W-1:0]   mem [WINDOW];
  logic [IV_W-1:0]   rd_data;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_en;

  logic [TS_W-1:0]   prev_time;
  logic [ADDR_W-1:0] write_pos;
  logic [CNT_W-1:0]  fill_count;
  logic [SUM_W-1:0]  running_sum;
  logic [IV_W-1:0]   iv;
  logic              recorded;
  logic [TS_W-1:0]   diff;

  logic              scan_active;
  logic              scan_pend;
  logic [CNT_W-1:0]  scan_idx;
  logic              scan_read;
  logic [IV_W-1:0]   peak;

  logic [AVG_W-1:0]  avg_q;
  logic [RATE_W-1:0] rate_q;

  logic              div_start;
  logic              div_done;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quotient;
  logic [NUM_W-1:0]  rate_num;

  // Interval since the previous frame; iv saturates it to the interval width.
  assign diff = timestamp_us - prev_time;

  // Memory read port: the oldest entry on accept, then the scan walk.
  assign scan_read = scan_active && (scan_idx < fill_count);
  assign rd_en     = cmd.accept || scan_read;
  assign rd_addr   = cmd.accept ? write_pos : scan_idx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (cmd.commit && recorded) begin
      mem[write_pos] <= iv;
    end
  end

  // Window state: previous time, ring position, fill count and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time   <= '0;
      write_pos   <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      recorded    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        prev_time <= timestamp_us;
        recorded  <= (prev_time != '0);
      end
      if (cmd.commit && recorded) begin
        write_pos <= (write_pos == POS_LAST) ? '0 : write_pos + ADDR_W'(1);
        if (fill_count == CNT_FULL) begin
          running_sum <= running_sum - SUM_W'(rd_data) + SUM_W'(iv);
        end else begin
          fill_count  <= fill_count + CNT_W'(1);
          running_sum <= running_sum + SUM_W'(iv);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      iv <= (|diff[TS_W-1:IV_W]) ? '1 : diff[IV_W-1:0];
    end
  end

  // Peak scan over the held entries, one read per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_active <= 1'b0;
      scan_pend   <= 1'b0;
      scan_idx    <= '0;
    end else if (cmd.start) begin
      scan_active <= 1'b1;
      scan_pend   <= 1'b0;
      scan_idx    <= '0;
    end else if (scan_active) begin
      scan_pend <= scan_read;
      if (scan_read) begin
        scan_idx <= scan_idx + CNT_W'(1);
      end else begin
        scan_active <= 1'b0;
      end
    end else begin
      scan_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      peak <= '0;
    end else if (scan_pend && (rd_data > peak)) begin
      peak <= rd_data;
    end
  end

  // Divider operands: average first, then the rate.
  assign rate_num     = NUM_W'(RATE_SCALE) * NUM_W'(fill_count);
  assign div_start    = cmd.start || cmd.latch_avg;
  assign div_dividend = cmd.latch_avg ? DIV_W'(rate_num) : DIV_W'(running_sum);
  assign div_divisor  = cmd.latch_avg ? DIV_W'(running_sum) : DIV_W'(fill_count);

  fiws_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Quotient capture with the empty-window and saturation cases.
  always_ff @(posedge clk) begin
    if (cmd.latch_avg) begin
      avg_q <= (fill_count == '0) ? '0 : div_quotient[AVG_W-1:0];
    end
    if (cmd.latch_rate) begin
      if (running_sum == '0) begin
        rate_q <= '0;
      end else if (div_quotient > DIV_W'(RATE_MAX)) begin
        rate_q <= RATE_MAX;
      end else begin
        rate_q <= div_quotient[RATE_W-1:0];
      end
    end
  end

  // Output beat register, loaded while the previous beat drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      interval_recorded <= recorded;
      frame_count       <= fill_count;
      window_sum_us     <= running_sum;
      average_us        <= avg_q;
      peak_us           <= peak;
      rate_tenths_fps   <= rate_q;
    end
  end

  assign status.div_done  = div_done;
  assign status.scan_done = !scan_active && !scan_pend;
  assign status.out_free  = !out_valid || out_ready;

endmodule

/* verif/frame_stats_checker.sv */
// Checker that predicts and compares the frame interval window statistics of each result beat.
module frame_stats_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [fiws_pkg::TS_W-1:0]   timestamp_us,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic                        interval_recorded,
  input  logic [fiws_pkg::CNT_W-1:0]  frame_count,
  input  logic [fiws_pkg::SUM_W-1:0]  window_sum_us,
  input  logic [fiws_pkg::AVG_W-1:0]  average_us,
  input  logic [fiws_pkg::IV_W-1:0]   peak_us,
  input  logic [fiws_pkg::RATE_W-1:0] rate_tenths_fps,
  output int                          fail_count,
  output int                          pending
);

  import fiws_pkg::*;

  localparam logic [63:0] TENTHS_PER_US = 64'd10000000;
  localparam logic [63:0] RATE_CEILING  = 64'd10000000;
  localparam logic [63:0] IV_CEILING    = 64'hFFFF_FFFF;
  localparam int          REPORT_LIMIT  = 10;

  typedef struct packed {
    logic              recorded;
    logic [CNT_W-1:0]  count;
    logic [SUM_W-1:0]  sum;
    logic [AVG_W-1:0]  avg;
    logic [IV_W-1:0]   peak;
    logic [RATE_W-1:0] rate;
  } frame_stats_t;

  // Shadow copy of the window state.
  logic [IV_W-1:0] interval_ring [WINDOW];
  int              ring_pos;
  int              held_count;
  logic [63:0]     last_time;
  logic [63:0]     held_sum;

  frame_stats_t    expected_stats_q [$];
  int              errors;

  // Adds the interval since the last timestamp and works out the statistics.
  function automatic frame_stats_t predict_window_stats(input logic [63:0] now);
    frame_stats_t r;
    logic [63:0]  diff;
    logic [63:0]  quotient;
    logic [31:0]  iv;
    logic [31:0]  peak;
    r = '0;
    if (last_time != 64'd0) begin
      diff = now - last_time;
      iv = (diff > IV_CEILING) ? 32'hFFFF_FFFF : diff[31:0];
      if (held_count >= WINDOW) begin
        held_sum -= 64'(interval_ring[ring_pos]);
      end else begin
        held_count++;
      end
      interval_ring[ring_pos] = iv;
      held_sum += 64'(iv);
      ring_pos = (ring_pos + 1) % WINDOW;
      r.recorded = 1'b1;
    end
    last_time = now;

    // The ring fills from slot zero, so the first held_count slots are the live ones.
    peak = '0;
    for (int i = 0; i < held_count; i++) begin
      if (interval_ring[i] > peak) peak = interval_ring[i];
    end

    r.count = CNT_W'(held_count);
    r.sum   = held_sum[SUM_W-1:0];
    r.peak  = peak;
    if (held_count != 0) begin
      quotient = held_sum / 64'(held_count);
      r.avg = quotient[AVG_W-1:0];
    end
    if (held_sum != 64'd0) begin
      quotient = (TENTHS_PER_US * 64'(held_count)) / held_sum;
      if (quotient > RATE_CEILING) quotient = RATE_CEILING;
      r.rate = quotient[RATE_W-1:0];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
    if (exp !== act) begin
      errors++;
      if (errors <= REPORT_LIMIT) begin
        $display("mismatch on %s: expected %0d, got %0d", name, exp, act);
      end
    end
  endtask

  // Input beats feed the predictor; result beats are compared with the oldest prediction.
  always @(posedge clk) begin
    frame_stats_t exp;
    if (rst) begin
      ring_pos   = 0;
      held_count = 0;
      last_time  = '0;
      held_sum   = '0;
      expected_stats_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_stats_q.push_back(predict_window_stats(timestamp_us));
      end
      if (out_valid && out_ready) begin
        if (expected_stats_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("result beat with no prediction waiting: count %0d sum %0d",
                     frame_count, window_sum_us);
          end
        end else begin
          exp = expected_stats_q.pop_front();
          check_field("interval_recorded", 64'(exp.recorded), 64'(interval_recorded));
          check_field("frame_count", 64'(exp.count), 64'(frame_count));
          check_field("window_sum_us", 64'(exp.sum), 64'(window_sum_us));
          check_field("average_us", 64'(exp.avg), 64'(average_us));
          check_field("peak_us", 64'(exp.peak), 64'(peak_us));
          check_field("rate_tenths_fps", 64'(exp.rate), 64'(rate_tenths_fps));
        end
      end
    end
    pending    <= expected_stats_q.size();
    fail_count <= errors;
  end

endmodule

/* verif/tb_top.sv */
// Top of the frame interval statistics testbench: clock, reset, stimulus, receiver and verdict.
module tb_top;

  import fiws_pkg::*;

  localparam int RANDOM_ITEMS  = 1230;
  localparam int HOLD_AT_ITEM  = 450;
  localparam int HOLD_CYCLES   = 3000;
  localparam int DRAIN_AT_ITEM = 900;
  localparam int IDLE_LIMIT    = 20000;
  localparam int TAIL_CYCLES   = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [TS_W-1:0]   timestamp_us = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              interval_recorded;
  logic [CNT_W-1:0]  frame_count;
  logic [SUM_W-1:0]  window_sum_us;
  logic [AVG_W-1:0]  average_us;
  logic [IV_W-1:0]   peak_us;
  logic [RATE_W-1:0] rate_tenths_fps;
  int                fail_count;
  int                pending;

  int                sent_count = 0;
  int                burst_left = 0;
  int                idle_cycles = 0;
  logic [63:0]       stamp;

  frame_interval_window_stats_unit i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .timestamp_us      (timestamp_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .interval_recorded (interval_recorded),
    .frame_count       (frame_count),
    .window_sum_us     (window_sum_us),
    .average_us        (average_us),
    .peak_us           (peak_us),
    .rate_tenths_fps   (rate_tenths_fps)
  );

  frame_stats_checker i_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .timestamp_us      (timestamp_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .interval_recorded (interval_recorded),
    .frame_count       (frame_count),
    .window_sum_us     (window_sum_us),
    .average_us        (average_us),
    .peak_us           (peak_us),
    .rate_tenths_fps   (rate_tenths_fps),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  always #5 clk = ~clk;

  // Offers one timestamp beat, waits for it to be taken, then paces the next burst.
  task automatic send_timestamp(input logic [63:0] ts);
    int gap;
    in_valid     <= 1'b1;
    timestamp_us <= ts;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // Mostly short bursts, now and then a long run with no gaps.
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 100)
                                                : $urandom_range(0, 7);
    end
  endtask

  // Stops offering until every predicted result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Next timestamp of the random part; the saturating phase leans on huge jumps.
  function automatic logic [63:0] next_stamp(input logic [63:0] cur, input bit big_phase);
    int pick;
    pick = $urandom_range(0, 99);
    if (big_phase && pick < 70) return cur + 64'h1_0000_0000 + 64'($urandom);
    if (pick < 55) return cur + 64'(16000 + $urandom_range(0, 2000));
    if (pick < 70) return cur + 64'($urandom_range(0, 50));
    if (pick < 80) return cur + 64'($urandom);
    if (pick < 86) return cur + 64'h1_0000_0000 + 64'($urandom);
    if (pick < 91) return cur - 64'($urandom_range(1, 100000));
    if (pick < 94) return 64'd0;
    return {$urandom(), $urandom()};
  endfunction

  // Stimulus: directed corner cases, then random timestamps.
  initial begin
    logic [63:0] directed_stamps [$];
    directed_stamps = '{
      64'd0, 64'd5, 64'd5, 64'd6, 64'd7,
      64'd16673, 64'd50006, 64'd100,
      64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_0010,
      64'h0000_0001_0000_0010, 64'h0000_0002_0000_000F, 64'h0000_0003_0000_000D,
      64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
      64'd0, 64'd1, 64'd16668, 64'd33335
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_stamps[k]) send_timestamp(directed_stamps[k]);
    drain_results();

    stamp = 64'd33335;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      stamp = next_stamp(stamp, (n >= 300) && (n < 600));
      send_timestamp(stamp);
      if (sent_count == DRAIN_AT_ITEM) drain_results();
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Receiver: ready patterns of its own, plus one long hold-off while beats keep being offered.
  initial begin
    int  mode;
    int  span;
    bit  held;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held && sent_count >= HOLD_AT_ITEM) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        span = $urandom_range(20, 300);
        repeat (span) begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
              out_ready <= ($urandom_range(0, 3) == 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

/* filelist.f */
design/fiws_pkg.sv
design/fiws_divider.sv
design/fiws_ctrl.sv
design/fiws_datapath.sv
design/frame_interval_window_stats_unit.sv
verif/frame_stats_checker.sv
verif/tb_top.sv
